### design/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// ssrs_pkg: shared types and constants of the smoothstep rate schedule
//
// Fixed formats, register indexes and the command/response structs that run
// between the sequencer and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package ssrs_pkg;

    // Q8.24 rates, Q0.16 ease fractions
    localparam int RATE_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int S_W       = FRAC_BITS + 1;

    // step registers carry at most this many bits on the config port
    localparam int STEP_CFG_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0] INITIAL_RATE_RST = 32'd16777;
    localparam logic [1:0]        STEP_COUNT_RST   = 2'd1;

    // 1.0 and 3.0 in Q0.16
    localparam logic [S_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0]    THREE_Q16 = 18'd196608;

    // shift-add multiplier geometry
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_RATE = 3'd0,
        REG_STEP_COUNT   = 3'd1,
        REG_STEP_0       = 3'd2,
        REG_STEP_1       = 3'd3,
        REG_STEP_2       = 3'd4,
        REG_TARGET_0     = 3'd5,
        REG_TARGET_1     = 3'd6,
        REG_TARGET_2     = 3'd7
    } cfg_reg_t;

    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } div_rsp_t;

endpackage

### design/ssrs_div.sv
// ----------------------------------------------------------------------------
// ssrs_div: bit-serial fraction divider
//
// Restoring division of num by den, with num below den, one quotient bit per
// cycle. Gives floor(num * 2^16 / den) as a Q0.16 fraction.
// ----------------------------------------------------------------------------
module ssrs_div #(
    parameter int BATCH_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [BATCH_BITS-1:0] num,
    input  logic [BATCH_BITS-1:0] den,
    output ssrs_pkg::div_rsp_t    rsp
);

    localparam int CNT_W = $clog2(ssrs_pkg::FRAC_BITS + 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [BATCH_BITS-1:0]          rem_reg, rem_next;
    logic [BATCH_BITS-1:0]          den_reg, den_next;
    logic [ssrs_pkg::FRAC_BITS-1:0] quot_reg, quot_next;

    logic [BATCH_BITS:0] rem_shift;
    logic [BATCH_BITS:0] trial;
    logic                fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign trial     = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // the remainder stays below den, so it fits back in BATCH_BITS
            rem_next  = fits ? trial[BATCH_BITS-1:0] : rem_shift[BATCH_BITS-1:0];
            quot_next = {quot_reg[ssrs_pkg::FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ssrs_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### design/ssrs_mul.sv
// ----------------------------------------------------------------------------
// ssrs_mul: bit-serial shift-add multiplier
//
// Multiplies a 32-bit operand by an 18-bit operand, taking one bit of the
// second operand per cycle, LSB first. The product is held until next start.
// ----------------------------------------------------------------------------
module ssrs_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  ssrs_pkg::mul_cmd_t cmd,
    output ssrs_pkg::mul_rsp_t rsp
);

    localparam int A_W   = ssrs_pkg::MUL_A_W;
    localparam int B_W   = ssrs_pkg::MUL_B_W;
    localparam int P_W   = ssrs_pkg::MUL_P_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [P_W-1:0]   p_reg, p_next;

    logic [A_W:0] partial;

    // add the multiplicand into the upper half when the low bit is set
    assign partial = {1'b0, p_reg[P_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = cmd.a;
            p_next    = {{A_W{1'b0}}, cmd.b};
        end
        else if (busy_reg)
        begin
            p_next   = {partial, p_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = p_reg;

endmodule

### design/smoothstep_stepped_rate_schedule.sv
// ----------------------------------------------------------------------------
// smoothstep_stepped_rate_schedule: eased piecewise learning-rate schedule
//
// Finds the schedule segment of a batch number and eases the rate across it
// with the smoothstep curve 3t^2 - 2t^3; a restart item reloads the rate.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives one rate. An update that lands
// before the first step or between two steps runs a step scan, the restoring
// divider that forms t, three passes through one shift-add multiplier (t*t,
// times 3 - 2t, times the rate difference), a load of the output register and
// a return to idle to take the next item. A restart goes straight to the
// output load, and a batch at or past the last step in use skips the divider
// and the multiplier. A finished rate sits in the output register while the
// next item is taken in; a second finished rate waits, and holds off the
// input, until the output register is free.
module smoothstep_stepped_rate_schedule #(
    parameter int MAX_STEPS  = 3,
    parameter int BATCH_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [BATCH_BITS-1:0]               batch_number,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssrs_pkg::RATE_W-1:0]         rate
);

    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int STEP_KEEP = (BATCH_BITS < ssrs_pkg::STEP_CFG_W) ?
                               BATCH_BITS : ssrs_pkg::STEP_CFG_W;
    localparam logic [BATCH_BITS-1:0] STEP_MASK =
        BATCH_BITS'((64'd1 << STEP_KEEP) - 64'd1);
    localparam int RW = ssrs_pkg::RATE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_SQUARE,
        ST_CUBE,
        ST_SCALE,
        ST_DONE
    } state_t;

    // configuration
    logic [RW-1:0]         initial_rate_reg;
    logic [1:0]            step_count_reg;
    logic [BATCH_BITS-1:0] step_reg [MAX_STEPS];
    logic [RW-1:0]         target_reg [MAX_STEPS];

    // sequencer
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BATCH_BITS-1:0] batch_reg, batch_next;
    logic [BATCH_BITS-1:0] lo_step_reg, lo_step_next;
    logic [RW-1:0]         lo_tgt_reg, lo_tgt_next;
    logic [RW-1:0]         from_reg, from_next;
    logic [RW-1:0]         to_reg, to_next;
    logic [ssrs_pkg::FRAC_BITS-1:0] t_reg, t_next;
    logic [RW-1:0]         res_reg, res_next;
    logic [RW-1:0]         current_rate_reg, current_rate_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RW-1:0]         rate_reg, rate_next;
    logic                  div_start_reg, div_start_next;
    logic [BATCH_BITS-1:0] div_num_reg, div_num_next;
    logic [BATCH_BITS-1:0] div_den_reg, div_den_next;
    ssrs_pkg::mul_cmd_t    mul_cmd_reg, mul_cmd_next;

    ssrs_pkg::div_rsp_t    div_rsp;
    ssrs_pkg::mul_rsp_t    mul_rsp;

    logic [CNT_W-1:0]      n_eff;
    logic [BATCH_BITS-1:0] step_sel;
    logic [RW-1:0]         tgt_sel;
    logic                  rising;
    logic [RW-1:0]         diff;
    logic [17:0]           s_raw;
    logic [ssrs_pkg::S_W-1:0] s_val;
    logic [RW-1:0]         delta;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_rate_reg <= ssrs_pkg::INITIAL_RATE_RST;
            step_count_reg   <= ssrs_pkg::STEP_COUNT_RST;
            for (int j = 0; j < MAX_STEPS; j++)
            begin
                step_reg[j]   <= '0;
                target_reg[j] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ssrs_pkg::REG_INITIAL_RATE: initial_rate_reg <= cfg_data[RW-1:0];
                ssrs_pkg::REG_STEP_COUNT:   step_count_reg   <= cfg_data[1:0];
                default: ;
            endcase
            for (int j = 0; j < MAX_STEPS; j++)
            begin
                if (cfg_index == ssrs_pkg::CFG_IDX_W'(int'(ssrs_pkg::REG_STEP_0) + j))
                    step_reg[j] <= cfg_data[BATCH_BITS-1:0] & STEP_MASK;
                if (cfg_index == ssrs_pkg::CFG_IDX_W'(int'(ssrs_pkg::REG_TARGET_0) + j))
                    target_reg[j] <= cfg_data[RW-1:0];
            end
        end
    end

    // steps in use: zero acts as one, clamp to the number stored
    always_comb
    begin
        if (step_count_reg == 2'd0)
            n_eff = CNT_W'(1);
        else if (32'(step_count_reg) > MAX_STEPS)
            n_eff = CNT_W'(MAX_STEPS);
        else
            n_eff = CNT_W'(step_count_reg);
    end

    // step and target under the scan pointer
    always_comb
    begin
        step_sel = '0;
        tgt_sel  = '0;
        for (int j = 0; j < MAX_STEPS; j++)
        begin
            if (cnt_reg == CNT_W'(j))
            begin
                step_sel = step_reg[j];
                tgt_sel  = target_reg[j];
            end
        end
    end

    // ease arithmetic
    assign rising = (to_reg >= from_reg);
    assign diff   = rising ? (to_reg - from_reg) : (from_reg - to_reg);
    assign s_raw  = mul_rsp.product[ssrs_pkg::MUL_P_W-1:32];
    assign s_val  = (s_raw > 18'(ssrs_pkg::ONE_Q16)) ? ssrs_pkg::ONE_Q16
                                                     : s_raw[ssrs_pkg::S_W-1:0];
    assign delta  = mul_rsp.product[RW+15:16];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        batch_next        = batch_reg;
        lo_step_next      = lo_step_reg;
        lo_tgt_next       = lo_tgt_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        t_next            = t_reg;
        res_next          = res_reg;
        current_rate_next = current_rate_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        rate_next         = rate_reg;
        div_start_next    = 1'b0;
        div_num_next      = div_num_reg;
        div_den_next      = div_den_reg;
        mul_cmd_next      = mul_cmd_reg;
        mul_cmd_next.start = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == ssrs_pkg::FUNC_RESTART)
                    begin
                        res_next   = initial_rate_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        batch_next = batch_number;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg == n_eff)
                begin
                    // at or past the last step in use: hold its target
                    res_next   = lo_tgt_reg;
                    state_next = ST_DONE;
                end
                else if (step_sel > batch_reg)
                begin
                    // the span is always positive here: step_sel > batch >= lo_step
                    if (cnt_reg == '0)
                    begin
                        div_num_next = batch_reg;
                        div_den_next = step_sel;
                        from_next    = current_rate_reg;
                    end
                    else
                    begin
                        div_num_next = batch_reg - lo_step_reg;
                        div_den_next = step_sel - lo_step_reg;
                        from_next    = lo_tgt_reg;
                    end
                    to_next        = tgt_sel;
                    div_start_next = 1'b1;
                    state_next     = ST_DIV;
                end
                else
                begin
                    lo_step_next = step_sel;
                    lo_tgt_next  = tgt_sel;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    t_next             = div_rsp.quot;
                    mul_cmd_next.start = 1'b1;
                    mul_cmd_next.a     = ssrs_pkg::MUL_A_W'(div_rsp.quot);
                    mul_cmd_next.b     = ssrs_pkg::MUL_B_W'(div_rsp.quot);
                    state_next         = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    // t below 1.0, so t^2 fits 32 bits
                    mul_cmd_next.start = 1'b1;
                    mul_cmd_next.a     = mul_rsp.product[ssrs_pkg::MUL_A_W-1:0];
                    mul_cmd_next.b     = ssrs_pkg::THREE_Q16 - {1'b0, t_reg, 1'b0};
                    state_next         = ST_CUBE;
                end
            end

            ST_CUBE:
            begin
                if (mul_rsp.done)
                begin
                    mul_cmd_next.start = 1'b1;
                    mul_cmd_next.a     = diff;
                    mul_cmd_next.b     = ssrs_pkg::MUL_B_W'(s_val);
                    state_next         = ST_SCALE;
                end
            end

            ST_SCALE:
            begin
                if (mul_rsp.done)
                begin
                    res_next   = rising ? (from_reg + delta) : (from_reg - delta);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    rate_next         = res_reg;
                    current_rate_next = res_reg;
                    state_next        = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            batch_reg        <= '0;
            lo_step_reg      <= '0;
            lo_tgt_reg       <= '0;
            from_reg         <= '0;
            to_reg           <= '0;
            t_reg            <= '0;
            res_reg          <= '0;
            current_rate_reg <= ssrs_pkg::INITIAL_RATE_RST;
            out_valid_reg    <= 1'b0;
            rate_reg         <= '0;
            div_start_reg    <= 1'b0;
            div_num_reg      <= '0;
            div_den_reg      <= '0;
            mul_cmd_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            batch_reg        <= batch_next;
            lo_step_reg      <= lo_step_next;
            lo_tgt_reg       <= lo_tgt_next;
            from_reg         <= from_next;
            to_reg           <= to_next;
            t_reg            <= t_next;
            res_reg          <= res_next;
            current_rate_reg <= current_rate_next;
            out_valid_reg    <= out_valid_next;
            rate_reg         <= rate_next;
            div_start_reg    <= div_start_next;
            div_num_reg      <= div_num_next;
            div_den_reg      <= div_den_next;
            mul_cmd_reg      <= mul_cmd_next;
        end
    end

    ssrs_div #(
        .BATCH_BITS (BATCH_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .rsp   (div_rsp)
    );

    ssrs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd_reg),
        .rsp   (mul_rsp)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rate      = rate_reg;

endmodule
